[rtl/nrmc_pkg.sv]
package nrmc_pkg;

    // Field widths of the stream words.
    localparam int BYTE_W    = 8;
    localparam int ACC_W     = 31;
    localparam int HEMI_W    = 8;
    localparam int TDATA_W   = 80;
    localparam int CFG_IDX_W = 8;

    // Default sizing of the parse counters.
    localparam int MAX_SENTENCE_LEN = 32767;
    localparam int MAX_COMMAS       = 12;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] DEFAULT_MIN_LENGTH  = 8'd20;
    localparam logic [BYTE_W-1:0] DEFAULT_TYPE_LETTER = 8'h52;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_LETTER = 8'd1;

    // ASCII characters the parser looks for.
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

    // Saturation value of the coordinate accumulators.
    localparam logic [ACC_W-1:0] ACC_MAX = 31'h7FFF_FFFF;

    // Per-field parse status.
    typedef struct packed {
        logic hemi;   // hemisphere byte captured
        logic bad;    // field is malformed
        logic dot;    // decimal point seen
        logic digit;  // digit seen since field start or since the dot
    } field_status_t;

endpackage

[rtl/nmea_rmc_position_extractor.sv]
// NMEA RMC position extractor.
// The slave stream takes one sentence character per word in s_tdata, with
// s_tlast high on the final character. For every sentence one word leaves on
// the master stream: m_tuser is the fix-valid flag, m_tdata carries latitude
// and longitude as integers (digits without the dot) and the two hemisphere
// characters. All coordinate fields read zero when the fix is not valid.
// The config channel writes min_length (index 0) and type_letter (index 1);
// it is always ready and should be written only while no sentence is in
// flight.
// A character is held in an input register and parsed from there, and parsing
// the final character loads the result word into the output register.
// One character is taken per cycle, unless a stalled receiver holds back a final
// character; the rate is set by the single parse stage between input and output.
// When the receiver stalls with a word pending, the final character of the
// next sentence waits in the input register and s_tready drops until the word
// is taken; the characters before it keep flowing into the parse state.
// Reset clears the parse state, empties both registers and restores the
// configuration defaults (min_length 20, type_letter 'R').
module nmea_rmc_position_extractor
#(
    parameter int MAX_SENTENCE_LEN = nrmc_pkg::MAX_SENTENCE_LEN,
    parameter int MAX_COMMAS       = nrmc_pkg::MAX_COMMAS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nrmc_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] rx_byte
    input  logic                                 s_tlast,   // end_flag
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [30:0] lat_scaled, [38:31] lat_hemi, [69:39] lon_scaled,
    // [77:70] lon_hemi, [79:78] zero
    output logic [nrmc_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                 m_tuser,   // fix_valid
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nrmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nrmc_pkg::BYTE_W-1:0]          cfg_data
);

    localparam int POS_W = $clog2(MAX_SENTENCE_LEN + 1);
    localparam int CNT_W = $clog2(MAX_COMMAS + 1);
    localparam int CMP_W = (POS_W > nrmc_pkg::BYTE_W) ? POS_W : nrmc_pkg::BYTE_W;
    localparam int PAD_W = nrmc_pkg::TDATA_W - 2 * nrmc_pkg::ACC_W - 2 * nrmc_pkg::HEMI_W;

    // Configuration registers.
    logic [nrmc_pkg::BYTE_W-1:0] min_len_reg;
    logic [nrmc_pkg::BYTE_W-1:0] type_letter_reg;

    // Input register.
    logic                        in_valid_reg;
    logic [nrmc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;

    // Parse state.
    logic [POS_W-1:0]              pos_reg,    pos_next;
    logic [CNT_W-1:0]              comma_reg,  comma_next;
    logic                          header_reg, header_next;
    logic [nrmc_pkg::ACC_W-1:0]    lat_acc_reg, lat_acc_next;
    logic [nrmc_pkg::ACC_W-1:0]    lon_acc_reg, lon_acc_next;
    nrmc_pkg::field_status_t       lat_st_reg, lat_st_cap, lat_st_next;
    nrmc_pkg::field_status_t       lon_st_reg, lon_st_cap, lon_st_next;
    logic [nrmc_pkg::HEMI_W-1:0]   lat_hemi_reg, lat_hemi_next;
    logic [nrmc_pkg::HEMI_W-1:0]   lon_hemi_reg, lon_hemi_next;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_fix_reg, out_fix_next;
    logic [nrmc_pkg::TDATA_W-1:0]  out_data_reg, out_data_next;

    logic out_free;
    logic proc;
    logic is_comma;
    logic fix_ok;

    // Handshake: the final character waits for a free output register.
    assign out_free  = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_fix_reg;

    assign is_comma = (in_byte_reg == nrmc_pkg::CHAR_COMMA);

    // Header, position and comma bookkeeping, plus hemisphere capture.
    always_comb
    begin
        header_next = header_reg;
        if (pos_reg == POS_W'(0) && in_byte_reg != nrmc_pkg::CHAR_DOLLAR)
            header_next = 1'b0;
        if (pos_reg == POS_W'(3) && in_byte_reg != type_letter_reg)
            header_next = 1'b0;

        pos_next = pos_reg;
        if (pos_reg < POS_W'(MAX_SENTENCE_LEN))
            pos_next = pos_reg + POS_W'(1);

        comma_next = comma_reg;
        if (is_comma && comma_reg < CNT_W'(MAX_COMMAS))
            comma_next = comma_reg + CNT_W'(1);

        lat_hemi_next = lat_hemi_reg;
        lat_st_cap    = lat_st_reg;
        if (comma_reg == CNT_W'(4) && !lat_st_reg.hemi)
        begin
            lat_hemi_next   = in_byte_reg;
            lat_st_cap.hemi = 1'b1;
        end

        lon_hemi_next = lon_hemi_reg;
        lon_st_cap    = lon_st_reg;
        if (comma_reg == CNT_W'(6) && !lon_st_reg.hemi)
        begin
            lon_hemi_next   = in_byte_reg;
            lon_st_cap.hemi = 1'b1;
        end
    end

    // Latitude field sits after the third comma.
    nrmc_field_acc u_lat
    (
        .en       (!is_comma && comma_reg == CNT_W'(3)),
        .rx_byte  (in_byte_reg),
        .acc      (lat_acc_reg),
        .st       (lat_st_cap),
        .acc_next (lat_acc_next),
        .st_next  (lat_st_next)
    );

    // Longitude field sits after the fifth comma.
    nrmc_field_acc u_lon
    (
        .en       (!is_comma && comma_reg == CNT_W'(5)),
        .rx_byte  (in_byte_reg),
        .acc      (lon_acc_reg),
        .st       (lon_st_cap),
        .acc_next (lon_acc_next),
        .st_next  (lon_st_next)
    );

    // Sentence checks and the result word.
    always_comb
    begin
        fix_ok = header_next
              && (pos_next >= POS_W'(4))
              && (CMP_W'(pos_next) >= CMP_W'(min_len_reg))
              && (comma_next >= CNT_W'(6))
              && lat_st_next.digit && lat_st_next.dot && !lat_st_next.bad
              && lon_st_next.digit && lon_st_next.dot && !lon_st_next.bad;
        out_fix_next = fix_ok;
        if (fix_ok)
            out_data_next = {PAD_W'(0), lon_hemi_next, lon_acc_next,
                             lat_hemi_next, lat_acc_next};
        else
            out_data_next = '0;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg     <= nrmc_pkg::DEFAULT_MIN_LENGTH;
            type_letter_reg <= nrmc_pkg::DEFAULT_TYPE_LETTER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nrmc_pkg::REG_MIN_LENGTH:  min_len_reg     <= cfg_data;
                nrmc_pkg::REG_TYPE_LETTER: type_letter_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parse state advances per character and clears after the final one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            comma_reg    <= '0;
            header_reg   <= 1'b1;
            lat_acc_reg  <= '0;
            lon_acc_reg  <= '0;
            lat_st_reg   <= '0;
            lon_st_reg   <= '0;
            lat_hemi_reg <= '0;
            lon_hemi_reg <= '0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                pos_reg      <= '0;
                comma_reg    <= '0;
                header_reg   <= 1'b1;
                lat_acc_reg  <= '0;
                lon_acc_reg  <= '0;
                lat_st_reg   <= '0;
                lon_st_reg   <= '0;
                lat_hemi_reg <= '0;
                lon_hemi_reg <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                comma_reg    <= comma_next;
                header_reg   <= header_next;
                lat_acc_reg  <= lat_acc_next;
                lon_acc_reg  <= lon_acc_next;
                lat_st_reg   <= lat_st_next;
                lon_st_reg   <= lon_st_next;
                lat_hemi_reg <= lat_hemi_next;
                lon_hemi_reg <= lon_hemi_next;
            end
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            out_fix_reg  <= out_fix_next;
            out_data_reg <= out_data_next;
        end
    end

`ifndef ASSERT_OFF
    // A rejected sentence carries no coordinates.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid fix with nonzero coordinates");

    // The final character leaves the parse state cleared for the next sentence.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> (pos_reg == '0 && comma_reg == '0 && header_reg))
        else $error("parse state not cleared after final character");

    // A final character is only parsed when the output register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |-> out_free)
        else $error("result overwrote a pending word");

    // The comma counter never passes its ceiling.
    a_comma_bound: assert property (@(posedge clk) disable iff (!rst_n)
        comma_reg <= CNT_W'(MAX_COMMAS))
        else $error("comma counter overflow");
`endif

endmodule

[rtl/nrmc_field_acc.sv]
module nrmc_field_acc
(
    input  logic                               en,
    input  logic [nrmc_pkg::BYTE_W-1:0]        rx_byte,
    input  logic [nrmc_pkg::ACC_W-1:0]         acc,
    input  nrmc_pkg::field_status_t            st,
    output logic [nrmc_pkg::ACC_W-1:0]         acc_next,
    output nrmc_pkg::field_status_t            st_next
);

    localparam int PROD_W = nrmc_pkg::ACC_W + 4;

    logic                           is_digit;
    logic [nrmc_pkg::BYTE_W-1:0]    digit_val;
    logic [PROD_W-1:0]              acc_wide;
    logic [PROD_W-1:0]              sum;

    // Times ten as two shifted copies, plus the new digit.
    assign is_digit  = (rx_byte >= nrmc_pkg::CHAR_ZERO) && (rx_byte <= nrmc_pkg::CHAR_NINE);
    assign digit_val = rx_byte - nrmc_pkg::CHAR_ZERO;
    assign acc_wide  = PROD_W'(acc);
    assign sum       = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(digit_val[3:0]);

    // Accumulate digits, skip one dot, and flag anything else as bad.
    always_comb
    begin
        acc_next = acc;
        st_next  = st;
        if (en)
        begin
            if (is_digit)
            begin
                if (sum > PROD_W'(nrmc_pkg::ACC_MAX))
                    acc_next = nrmc_pkg::ACC_MAX;
                else
                    acc_next = sum[nrmc_pkg::ACC_W-1:0];
                st_next.digit = 1'b1;
            end
            else if (rx_byte == nrmc_pkg::CHAR_DOT)
            begin
                if (st.dot || !st.digit)
                    st_next.bad = 1'b1;
                st_next.dot   = 1'b1;
                st_next.digit = 1'b0;
            end
            else
            begin
                st_next.bad = 1'b1;
            end
        end
    end

endmodule

[test/nmea_rmc_position_extractor_tb.sv]
`timescale 1ns / 1ps

module nmea_rmc_position_extractor_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 29;

    // One sentence character as it is handed to the slave stream.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } char_word_t;

    // One decoded position word.
    typedef struct packed {
        logic                       fix;
        logic [nrmc_pkg::ACC_W-1:0] lat;
        logic [7:0]                 lat_h;
        logic [nrmc_pkg::ACC_W-1:0] lon;
        logic [7:0]                 lon_h;
    } fix_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [nrmc_pkg::BYTE_W-1:0]    s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [nrmc_pkg::TDATA_W-1:0]   m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [nrmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nrmc_pkg::BYTE_W-1:0]    cfg_data = '0;

    char_word_t pending_chars[$];
    fix_word_t  expected_fixes[$];
    logic [7:0] line_buf[$];

    // Shadow copy of the parser state and configuration.
    logic [7:0]              min_len_reg;
    logic [7:0]              type_letter_reg;
    logic [14:0]             char_pos;
    logic [3:0]              comma_cnt;
    logic                    hdr_ok;
    logic [30:0]             lat_acc;
    logic [30:0]             lon_acc;
    nrmc_pkg::field_status_t lat_st;
    nrmc_pkg::field_status_t lon_st;
    logic [7:0]              lat_hemi_r;
    logic [7:0]              lon_hemi_r;

    logic      s_fire = 1'b0;
    bit        no_idle = 1'b0;
    int        cycle_count = 0;
    int        mismatches = 0;
    int        results_checked = 0;
    int        valid_fixes = 0;
    int        chars_queued = 0;
    int        chars_accepted = 0;
    int        cfg_writes = 0;
    fix_word_t got_word;
    fix_word_t want_word;

    nmea_rmc_position_extractor DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Return the parser to the start of a sentence.
    task automatic clear_sentence();
        char_pos   = '0;
        comma_cnt  = '0;
        hdr_ok     = 1'b1;
        lat_acc    = '0;
        lon_acc    = '0;
        lat_st     = '0;
        lon_st     = '0;
        lat_hemi_r = '0;
        lon_hemi_r = '0;
    endtask

    // Fold one character into a coordinate field; digits accumulate with saturation.
    task automatic coord_char(input logic [7:0] c, inout logic [30:0] acc,
                              inout nrmc_pkg::field_status_t st);
        longint unsigned v;
        if (c >= nrmc_pkg::CHAR_ZERO && c <= nrmc_pkg::CHAR_NINE)
        begin
            v = acc;
            v = v * 10 + (c - nrmc_pkg::CHAR_ZERO);
            acc = (v > nrmc_pkg::ACC_MAX) ? nrmc_pkg::ACC_MAX : v[30:0];
            st.digit = 1'b1;
        end
        else if (c == nrmc_pkg::CHAR_DOT)
        begin
            if (st.dot || !st.digit)
                st.bad = 1'b1;
            st.dot   = 1'b1;
            st.digit = 1'b0;
        end
        else
        begin
            st.bad = 1'b1;
        end
    endtask

    // Predict the effect of one accepted character; the final one yields a position word.
    task automatic parse_char(input logic [7:0] c, input logic eos);
        fix_word_t w;
        logic      ok;
        if (char_pos == 0 && c != nrmc_pkg::CHAR_DOLLAR)
            hdr_ok = 1'b0;
        if (char_pos == 3 && c != type_letter_reg)
            hdr_ok = 1'b0;
        if (comma_cnt == 4 && !lat_st.hemi)
        begin
            lat_hemi_r  = c;
            lat_st.hemi = 1'b1;
        end
        if (comma_cnt == 6 && !lon_st.hemi)
        begin
            lon_hemi_r  = c;
            lon_st.hemi = 1'b1;
        end
        if (c == nrmc_pkg::CHAR_COMMA)
        begin
            if (comma_cnt < nrmc_pkg::MAX_COMMAS)
                comma_cnt = comma_cnt + 1'b1;
        end
        else if (comma_cnt == 3)
            coord_char(c, lat_acc, lat_st);
        else if (comma_cnt == 5)
            coord_char(c, lon_acc, lon_st);
        if (char_pos < nrmc_pkg::MAX_SENTENCE_LEN)
            char_pos = char_pos + 1'b1;
        if (eos)
        begin
            ok = hdr_ok && char_pos >= 4 && char_pos >= min_len_reg && comma_cnt >= 6
                 && lat_st.digit && lat_st.dot && !lat_st.bad
                 && lon_st.digit && lon_st.dot && !lon_st.bad;
            w = '0;
            if (ok)
            begin
                w.fix   = 1'b1;
                w.lat   = lat_acc;
                w.lat_h = lat_hemi_r;
                w.lon   = lon_acc;
                w.lon_h = lon_hemi_r;
            end
            expected_fixes.push_back(w);
            clear_sentence();
        end
    endtask

    // Sender: a word is held until taken; otherwise the next one goes out unless idling.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (s_tvalid && !s_fire)
            begin
                s_tvalid <= 1'b1;
            end
            else if (pending_chars.size() != 0
                     && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_chars[0].ch;
                s_tlast  <= pending_chars[0].eos;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
            m_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Monitor: predict on every accepted character, check every accepted result word.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            s_fire <= rst_n && s_tvalid && s_tready;
            if (rst_n && s_tvalid && s_tready)
            begin
                parse_char(s_tdata, s_tlast);
                void'(pending_chars.pop_front());
                chars_accepted++;
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                got_word.fix   = m_tuser;
                got_word.lat   = m_tdata[30:0];
                got_word.lat_h = m_tdata[38:31];
                got_word.lon   = m_tdata[69:39];
                got_word.lon_h = m_tdata[77:70];
                if (expected_fixes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with none expected: fix=%0d lat=%0d lon=%0d",
                                 $realtime, got_word.fix, got_word.lat, got_word.lon);
                end
                else
                begin
                    want_word = expected_fixes.pop_front();
                    results_checked++;
                    if (want_word.fix)
                        valid_fixes++;
                    if (got_word !== want_word || m_tdata[79:78] !== 2'b00)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("%0t: mismatch, expected fix=%0d lat=%0d %0h lon=%0d %0h,",
                                   $realtime, want_word.fix, want_word.lat, want_word.lat_h,
                                   want_word.lon, want_word.lon_h);
                            $display(" got fix=%0d lat=%0d %0h lon=%0d %0h pad=%0b",
                                     got_word.fix, got_word.lat, got_word.lat_h,
                                     got_word.lon, got_word.lon_h, m_tdata[79:78]);
                        end
                    end
                end
            end
        end
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        repeat (n)
            line_buf.push_back(8'(nrmc_pkg::CHAR_ZERO + $urandom_range(9)));
    endtask

    // Hand the built line to the sender, marking its final character.
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            pending_chars.push_back('{line_buf[i], i == line_buf.size() - 1});
        chars_queued += line_buf.size();
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_line();
    endtask

    // Coordinate field: mostly well formed, sometimes huge, empty or malformed.
    task automatic put_coord();
        int         roll;
        logic [7:0] b;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            put_digits($urandom_range(1, 5));
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(1, 5));
        end
        else if (roll < 76)
        begin
            put_digits($urandom_range(8, 12));
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(1, 6));
        end
        else if (roll < 80)
        begin
            // Empty field.
        end
        else if (roll < 85)
        begin
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(1, 4));
        end
        else if (roll < 90)
        begin
            put_digits($urandom_range(1, 4));
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
        end
        else if (roll < 95)
        begin
            put_digits($urandom_range(1, 3));
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(0, 3));
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(0, 3));
        end
        else
        begin
            // A stray character that is neither digit, dot nor comma.
            do
                b = 8'($urandom_range(255));
            while ((b >= nrmc_pkg::CHAR_ZERO && b <= nrmc_pkg::CHAR_NINE)
                   || b == nrmc_pkg::CHAR_COMMA || b == nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(0, 3));
            line_buf.push_back(b);
            put_digits($urandom_range(0, 3));
            line_buf.push_back(nrmc_pkg::CHAR_DOT);
            put_digits($urandom_range(1, 3));
        end
    endtask

    // Hemisphere character: usually one of the pair, sometimes any byte or left out.
    task automatic put_hemi(input string pair);
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            line_buf.push_back(pair[$urandom_range(1)]);
        else if (roll < 90)
            line_buf.push_back(8'($urandom_range(255)));
    endtask

    // One random sentence: mostly RMC-shaped with random content, the rest noise.
    task automatic queue_sentence(input int pad_odds);
        int keep;
        if ($urandom_range(99) < 12)
        begin
            if ($urandom_range(1) != 0)
                line_buf.push_back(nrmc_pkg::CHAR_DOLLAR);
            repeat ($urandom_range(1, 40))
                line_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            put_text("$GP");
            line_buf.push_back(($urandom_range(99) < 88) ? type_letter_reg
                                                         : 8'($urandom_range(255)));
            put_text("MC,");
            if ($urandom_range(1) != 0)
            begin
                put_digits(6);
                put_text(".");
                put_digits(2);
            end
            put_text(($urandom_range(3) == 0) ? ",V," : ",A,");
            put_coord();
            put_text(",");
            put_hemi("NS");
            put_text(",");
            put_coord();
            put_text(",");
            put_hemi("EW");
            repeat ($urandom_range(3))
            begin
                put_text(",");
                put_digits($urandom_range(0, 6));
            end
            if ($urandom_range(99) < pad_odds)
            begin
                put_text(",");
                repeat ($urandom_range(180, 250))
                    line_buf.push_back(8'($urandom_range(65, 90)));
            end
            if ($urandom_range(1) != 0)
                put_text("*4F");
            if ($urandom_range(99) < 5)
                line_buf[0] = 8'($urandom_range(255));
            if ($urandom_range(99) < 8)
            begin
                keep = $urandom_range(1, line_buf.size());
                while (line_buf.size() > keep)
                    void'(line_buf.pop_back());
            end
        end
        send_line();
    endtask

    task automatic random_phase(input int char_goal, input int pad_odds);
        int start;
        start = chars_queued;
        while (chars_queued - start < char_goal)
            queue_sentence(pad_odds);
    endtask

    // Block until every character is taken and every result word has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_chars.size() != 0 || expected_fixes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [nrmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == nrmc_pkg::REG_MIN_LENGTH)
            min_len_reg = val;
        else
            type_letter_reg = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        min_len_reg     = nrmc_pkg::DEFAULT_MIN_LENGTH;
        type_letter_reg = nrmc_pkg::DEFAULT_TYPE_LETTER;
        clear_sentence();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed sentences at the reset configuration.
        send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
        send_text("#GPRMC,123519,A,4807.038,N,01131.000,E*00");
        send_text("$GPGGA,123519,A,4807.038,N,01131.000,E*00");
        send_text("$");
        send_text("$GP");
        send_text("$GPRMC,,,1.1,N,2.2,E");
        send_text("$GPRMC,,,1.1,N,2.2,");
        send_text("$GPRMC,,,11.1,N,2.2,");
        send_text("$GPRMC,,,1.1,,2.2,,Z");
        send_text("$GPRMC,,A,.5,N,2.2,E,,,,");
        send_text("$GPRMC,,A,48.,N,2.2,E,,,,");
        send_text("$GPRMC,,A,4.8.0,N,2.2,E,,,,");
        send_text("$GPRMC,,A,4a.0,N,2.2,E,,,,");
        send_text("$GPRMC,,A,,N,2.2,E,,,,,,");
        send_text("$GPRMC,,A,1.1,N,,E,,,,,,");
        send_text("$GPRMC,,A,99999999999.99999,S,99999999999999.9,W,,");
        send_text("$GPRMC,,A,0.0,N,0.0,E,,,,,,,,,,,,,,,,,,");
        send_text("$GPRMC,,A,1234.5,N,12345.6");
        send_text("$GPRMC,,A,1234.5,N,12345.6,E");
        line_buf = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h7F};
        send_line();
        wait_drained();

        // Lowest settings of both registers.
        write_reg(nrmc_pkg::REG_MIN_LENGTH, 8'd0);
        write_reg(nrmc_pkg::REG_TYPE_LETTER, 8'd0);
        random_phase(150, 0);
        wait_drained();

        // Highest settings: only padded sentences can pass the length check.
        write_reg(nrmc_pkg::REG_MIN_LENGTH, 8'd255);
        write_reg(nrmc_pkg::REG_TYPE_LETTER, 8'd255);
        random_phase(600, 50);
        wait_drained();

        // Middle length with the usual letter, streamed with no idling at all.
        write_reg(nrmc_pkg::REG_MIN_LENGTH, 8'($urandom_range(10, 60)));
        write_reg(nrmc_pkg::REG_TYPE_LETTER, nrmc_pkg::DEFAULT_TYPE_LETTER);
        no_idle = 1'b1;
        random_phase(150, 0);
        wait_drained();
        no_idle = 1'b0;

        // Default length with a random letter.
        write_reg(nrmc_pkg::REG_MIN_LENGTH, nrmc_pkg::DEFAULT_MIN_LENGTH);
        write_reg(nrmc_pkg::REG_TYPE_LETTER, 8'($urandom_range(65, 90)));
        random_phase(150, 5);
        wait_drained();

        mismatches += expected_fixes.size();
        $display("Checked %0d position words (%0d with a valid fix) from %0d characters.",
                 results_checked, valid_fixes, chars_accepted);
        $display("Used %0d register writes covering both extremes of length and letter.",
                 cfg_writes);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
